/* rtl/box_filter_premultiplied_downscale_macros.svh */
// Assertion macros shared by the downscaler RTL.
`ifndef BOX_FILTER_PREMULTIPLIED_DOWNSCALE_MACROS_SVH
`define BOX_FILTER_PREMULTIPLIED_DOWNSCALE_MACROS_SVH
`ifndef SYNTHESIS
`define BFPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define BFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BFPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BFPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/bfpd_pkg.sv */
// Package with types, constants and helpers of the box filter downscaler.
`timescale 1ns / 1ps
`default_nettype none
package bfpd_pkg;
   localparam int MAX_SRC_DIM  = 512;
   localparam int MAX_DST_SIZE = 64;
   localparam int DIM_W        = 10;
   localparam int DST_W        = 7;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_DST_SIZE);
   localparam int SUM_W        = 26;
   localparam int CNT_W        = 19;
   localparam int EDGE_W       = 17;
   localparam int QUEUE_DEPTH  = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [DIM_W-1:0] RESET_SRC_WIDTH  = 10'd256;
   localparam logic [DIM_W-1:0] RESET_SRC_HEIGHT = 10'd256;
   localparam logic [DST_W-1:0] RESET_DST_SIZE   = 7'd32;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_SIZE   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic             restart;
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DST_W-1:0] dst_size;
   } cfg_type;

   typedef struct packed {
      logic             bad;
      logic             emit;
      logic             last_band;
      logic [DIM_W-1:0] rows;
      logic             col_end;
      logic [DIM_W-1:0] col_width;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] alpha;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } op_type;

   // c*a/255 truncated, exact for all 8-bit inputs.
   function automatic logic [PIX_W-1:0] premul(input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] a);
      logic [2*PIX_W-1:0] p;
      logic [2*PIX_W:0]   s;
      p = c * a;
      s = {1'b0, p} + {9'd0, p[2*PIX_W-1:PIX_W]} + 17'd1;
      return s[2*PIX_W-1:PIX_W];
   endfunction
endpackage
`default_nettype wire

/* rtl/bfpd_req_if.sv */
// Channel interface for incoming source pixels.
`timescale 1ns / 1ps
`default_nettype none
interface bfpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

/* rtl/bfpd_rsp_if.sv */
// Channel interface for outgoing downscaled pixels.
`timescale 1ns / 1ps
`default_nettype none
interface bfpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_alpha;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       row_last;
   logic       image_done;
   logic       bad_geometry;
   modport source (output valid, out_alpha, out_red, out_green, out_blue, row_last,
                   image_done, bad_geometry, input ready);
   modport sink   (input valid, out_alpha, out_red, out_green, out_blue, row_last,
                   image_done, bad_geometry, output ready);
endinterface
`default_nettype wire

/* rtl/bfpd_front.sv */
// Front end: tracks raster position and band edges, premultiplies pixels.
`timescale 1ns / 1ps
`default_nettype none
module bfpd_front import bfpd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   bfpd_req_if.sink     req,
   output logic         push_o,
   output op_type       op_o,
   input  wire logic    full_i
);
   logic [DIM_W-1:0]  sc_ff, sc_in, sr_ff, sr_in, cw_ff, cw_in, rc_ff, rc_in;
   logic [COL_W-1:0]  oc_ff, oc_in, orow_ff, orow_in;
   logic [EDGE_W-1:0] cd_ff, cd_in, cx_ff, cx_in, rd_ff, rd_in, rx_ff, rx_in;
   logic              col_fresh_ff, col_fresh_in, row_fresh_ff, row_fresh_in;
   logic [EDGE_W-1:0] dx, wx, hx, cd, cx, rd, rx;
   logic [DIM_W-1:0]  sc_nx, sr_nx;
   logic              ok, col_end, row_end, band, frame_end, accept;

   assign ok = (cfg.dst_size != '0) && (cfg.dst_size <= DST_W'(MAX_DST_SIZE))
            && (cfg.src_width != '0) && (cfg.src_width <= DIM_W'(MAX_SRC_DIM))
            && (cfg.src_height != '0) && (cfg.src_height <= DIM_W'(MAX_SRC_DIM))
            && (DIM_W'(cfg.dst_size) <= cfg.src_width)
            && (DIM_W'(cfg.dst_size) <= cfg.src_height);

   assign dx = EDGE_W'(cfg.dst_size);
   assign wx = EDGE_W'(cfg.src_width);
   assign hx = EDGE_W'(cfg.src_height);

   // Band end test: column s ends band k when (s+2)*D > (k+1)*W, no divide needed.
   assign cd = col_fresh_ff ? {dx[EDGE_W-2:0], 1'b0} : cd_ff;
   assign cx = col_fresh_ff ? wx : cx_ff;
   assign rd = row_fresh_ff ? {dx[EDGE_W-2:0], 1'b0} : rd_ff;
   assign rx = row_fresh_ff ? hx : rx_ff;

   assign col_end   = cd > cx;
   assign band      = rd > rx;
   assign sc_nx     = sc_ff + DIM_W'(1);
   assign sr_nx     = sr_ff + DIM_W'(1);
   assign row_end   = sc_nx >= cfg.src_width;
   assign frame_end = sr_nx >= cfg.src_height;

   assign req.ready = !full_i;
   assign accept    = req.valid && !full_i;
   assign push_o    = accept;

   always_comb begin
      op_o.bad       = !ok;
      op_o.emit      = ok && row_end && band;
      op_o.last_band = (DST_W'(orow_ff) + DST_W'(1)) >= cfg.dst_size;
      op_o.rows      = rc_ff + DIM_W'(1);
      op_o.col_end   = col_end;
      op_o.col_width = cw_ff + DIM_W'(1);
      op_o.col       = oc_ff;
      op_o.alpha     = req.alpha;
      op_o.red       = premul(req.red, req.alpha);
      op_o.green     = premul(req.green, req.alpha);
      op_o.blue      = premul(req.blue, req.alpha);
   end

   always_comb begin
      sc_in = sc_ff;  sr_in = sr_ff;  cw_in = cw_ff;  rc_in = rc_ff;
      oc_in = oc_ff;  orow_in = orow_ff;
      cd_in = cd_ff;  cx_in = cx_ff;  rd_in = rd_ff;  rx_in = rx_ff;
      col_fresh_in = col_fresh_ff;
      row_fresh_in = row_fresh_ff;
      if (accept && ok) begin
         if (row_end) begin
            sc_in = '0;
            oc_in = '0;
            cw_in = '0;
            col_fresh_in = 1'b1;
            if (band) begin
               orow_in = orow_ff + COL_W'(1);
               rx_in   = rx + hx;
               rc_in   = '0;
            end else begin
               rx_in = rx;
               rc_in = rc_ff + DIM_W'(1);
            end
            rd_in = rd + dx;
            sr_in = sr_nx;
            row_fresh_in = 1'b0;
            if (frame_end) begin
               sr_in   = '0;
               orow_in = '0;
               rc_in   = '0;
               row_fresh_in = 1'b1;
            end
         end else begin
            sc_in = sc_nx;
            cd_in = cd + dx;
            col_fresh_in = 1'b0;
            if (col_end) begin
               oc_in = oc_ff + COL_W'(1);
               cx_in = cx + wx;
               cw_in = '0;
            end else begin
               cx_in = cx;
               cw_in = cw_ff + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         sc_ff <= '0;  sr_ff <= '0;  cw_ff <= '0;  rc_ff <= '0;
         oc_ff <= '0;  orow_ff <= '0;
         col_fresh_ff <= 1'b1;
         row_fresh_ff <= 1'b1;
      end else begin
         sc_ff <= sc_in;  sr_ff <= sr_in;  cw_ff <= cw_in;  rc_ff <= rc_in;
         oc_ff <= oc_in;  orow_ff <= orow_in;
         col_fresh_ff <= col_fresh_in;
         row_fresh_ff <= row_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cd_ff <= cd_in;  cx_ff <= cx_in;  rd_ff <= rd_in;  rx_ff <= rx_in;
   end
endmodule
`default_nettype wire

/* rtl/bfpd_queue.sv */
// Short queue of classified pixel operations between front and back end.
`timescale 1ns / 1ps
`default_nettype none
`include "box_filter_premultiplied_downscale_macros.svh"
module bfpd_queue import bfpd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_i,
   input  wire op_type data_i,
   output logic        full_o,
   input  wire logic   pop_i,
   output op_type      data_o,
   output logic        empty_o
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]       count_ff;

   assign full_o  = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign empty_o = count_ff == '0;
   assign data_o  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop_i)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         unique case ({push_i, pop_i})
            2'b10:   count_ff <= count_ff + (PTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (PTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) slot_ff[wr_ptr_ff] <= data_i;
   end

   `BFPD_ASSERT_IMPLY(a_no_overflow, clock, reset, push_i, !full_o)
   `BFPD_ASSERT_IMPLY(a_no_underflow, clock, reset, pop_i, !empty_o)
endmodule
`default_nettype wire

/* rtl/bfpd_back.sv */
// Back end: column accumulators, row emission and per-box averaging.
`timescale 1ns / 1ps
`default_nettype none
`include "box_filter_premultiplied_downscale_macros.svh"
module bfpd_back import bfpd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire op_type  op_i,
   input  wire logic    empty_i,
   output logic         pop_o,
   bfpd_rsp_if.source   rsp
);
   typedef logic [3:0][SUM_W-1:0] sums_type;

   sums_type            sum_mem [MAX_DST_SIZE];
   logic [DIM_W-1:0]    colw_mem [MAX_DST_SIZE];
   logic [MAX_DST_SIZE-1:0] valid_ff;

   back_state_type      state_ff, state_in;
   logic                s1_v_ff, last_wr_v_ff, bad_ff, last_band_ff;
   op_type              s1_op_ff;
   sums_type            sum_q_ff, last_wr_data_ff, rem_ff, base, sum_new;
   logic                sum_qv_ff;
   logic [COL_W-1:0]    last_wr_col_ff, idx_ff, rd_addr;
   logic [DIM_W-1:0]    colw_q_ff, rows_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [2:0]          k_ff;
   logic [3:0][7:0]     q_ff;
   logic [SUM_W:0]      trial;
   logic                mem_we, clr_en, last_col;
   logic [3:0][7:0]     pix;

   assign pix      = {s1_op_ff.blue, s1_op_ff.green, s1_op_ff.red, s1_op_ff.alpha};
   assign rd_addr  = (state_ff == ST_ACC) ? op_i.col : idx_ff;
   assign last_col = (DST_W'(idx_ff) + DST_W'(1)) == cfg.dst_size;
   assign trial    = (SUM_W+1)'(cnt_ff) << k_ff;

   // The write of the previous cycle is not yet seen by this cycle's read data.
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         if (last_wr_v_ff && (last_wr_col_ff == s1_op_ff.col))
            base[ch] = last_wr_data_ff[ch];
         else
            base[ch] = sum_qv_ff ? sum_q_ff[ch] : '0;
         sum_new[ch] = base[ch] + SUM_W'(pix[ch]);
      end
   end

   always_comb begin
      state_in = state_ff;
      pop_o    = 1'b0;
      mem_we   = 1'b0;
      clr_en   = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            pop_o = !empty_i && !(s1_v_ff && (s1_op_ff.emit || s1_op_ff.bad));
            if (s1_v_ff) begin
               if (s1_op_ff.bad) begin
                  state_in = ST_OUT;
               end else begin
                  mem_we = 1'b1;
                  if (s1_op_ff.emit) state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            clr_en   = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (k_ff == '0) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = (bad_ff || last_col) ? ST_ACC : ST_READ;
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff     <= ST_ACC;
         s1_v_ff      <= 1'b0;
         last_wr_v_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_v_ff      <= pop_o;
         last_wr_v_ff <= mem_we;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         valid_ff <= '0;
      end else begin
         if (mem_we) valid_ff[s1_op_ff.col] <= 1'b1;
         if (clr_en) valid_ff[idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sum_q_ff  <= sum_mem[rd_addr];
      sum_qv_ff <= valid_ff[rd_addr];
      colw_q_ff <= colw_mem[idx_ff];
      if (mem_we) begin
         sum_mem[s1_op_ff.col] <= sum_new;
         if (s1_op_ff.col_end) colw_mem[s1_op_ff.col] <= s1_op_ff.col_width;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_o) s1_op_ff <= op_i;
      if (mem_we) begin
         last_wr_col_ff  <= s1_op_ff.col;
         last_wr_data_ff <= sum_new;
      end
      if (state_ff == ST_ACC && s1_v_ff) begin
         bad_ff <= s1_op_ff.bad;
         if (s1_op_ff.bad) q_ff <= '0;
         if (s1_op_ff.emit) begin
            idx_ff       <= '0;
            rows_ff      <= s1_op_ff.rows;
            last_band_ff <= s1_op_ff.last_band;
         end
      end
      if (state_ff == ST_LOAD) begin
         for (int ch = 0; ch < 4; ch++) rem_ff[ch] <= sum_qv_ff ? sum_q_ff[ch] : '0;
         cnt_ff <= CNT_W'(colw_q_ff) * CNT_W'(rows_ff);
         k_ff   <= 3'd7;
         q_ff   <= '0;
      end
      if (state_ff == ST_DIV) begin
         for (int ch = 0; ch < 4; ch++) begin
            if ({1'b0, rem_ff[ch]} >= trial) begin
               rem_ff[ch]     <= SUM_W'({1'b0, rem_ff[ch]} - trial);
               q_ff[ch][k_ff] <= 1'b1;
            end
         end
         k_ff <= k_ff - 3'd1;
      end
      if (state_ff == ST_OUT && rsp.ready && !bad_ff && !last_col)
         idx_ff <= idx_ff + COL_W'(1);
   end

   assign rsp.out_alpha    = q_ff[0];
   assign rsp.out_red      = q_ff[1];
   assign rsp.out_green    = q_ff[2];
   assign rsp.out_blue     = q_ff[3];
   assign rsp.row_last     = !bad_ff && last_col;
   assign rsp.image_done   = !bad_ff && last_col && last_band_ff;
   assign rsp.bad_geometry = bad_ff;

   `BFPD_ASSERT_IMPLY(a_no_op_during_emit, clock, reset, state_ff != ST_ACC, !s1_v_ff)
   `BFPD_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == ST_DIV && k_ff == '0, state_ff == ST_OUT)
endmodule
`default_nettype wire

/* rtl/box_filter_premultiplied_downscale.sv */
// Top level of the premultiplied-alpha box filter downscaler.
// Usage:
// Source RGBA8 pixels enter in raster order on the req_bus channel, one request
// per accepted valid/ready cycle. The image of src_width by src_height pixels is
// reduced to dst_size by dst_size pixels; results leave on rsp_bus.
// A pixel request is taken whenever the operation queue has room.
// Pixels inside a band produce no result. The last pixel of the last source row
// of a row band releases a whole output row: for each output column the back end
// reads the column sums, multiplies column width by band height, and runs a
// restoring divider for the eight quotient bits of each channel. The request
// channel keeps flowing into the four-entry queue during that time and stalls
// only once the queue is full.
// With bad geometry each request yields one result flagged bad_geometry.
// When the receiver holds rsp_bus.ready low, the result stays on the port and
// the back end waits; the front end stalls once the queue fills.
// Reset loads width 256, height 256, size 32 and clears the column sums through
// their valid bits at once; a write to one of the three registers over the CSR
// port restarts the frame the same way. Write registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module box_filter_premultiplied_downscale import bfpd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bfpd_req_if.sink                   req_bus,
   bfpd_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);
   logic [DIM_W-1:0] src_width_ff, src_height_ff;
   logic [DST_W-1:0] dst_size_ff;
   logic             wr_en, restart;
   cfg_type          cfg;
   op_type           push_op, pop_op;
   logic             push, pop, full, empty;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Any write to a listed register restarts the frame; unlisted addresses are ignored.
   always_comb begin
      restart    = 1'b0;
      csr_prdata = '0;
      case (reg_index_type'(csr_paddr[3:2]))
         REG_SRC_WIDTH: begin
            restart    = wr_en;
            csr_prdata = CSR_DATA_W'(src_width_ff);
         end
         REG_SRC_HEIGHT: begin
            restart    = wr_en;
            csr_prdata = CSR_DATA_W'(src_height_ff);
         end
         REG_DST_SIZE: begin
            restart    = wr_en;
            csr_prdata = CSR_DATA_W'(dst_size_ff);
         end
         default: begin
            restart    = 1'b0;
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RESET_SRC_WIDTH;
         src_height_ff <= RESET_SRC_HEIGHT;
         dst_size_ff   <= RESET_DST_SIZE;
      end else if (wr_en) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[DIM_W-1:0];
            REG_DST_SIZE:   dst_size_ff   <= csr_pwdata[DST_W-1:0];
            default:        dst_size_ff   <= dst_size_ff;
         endcase
      end
   end

   always_comb begin
      cfg.restart    = restart;
      cfg.src_width  = src_width_ff;
      cfg.src_height = src_height_ff;
      cfg.dst_size   = dst_size_ff;
   end

   bfpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req_bus),
      .push_o (push),
      .op_o   (push_op),
      .full_i (full)
   );

   bfpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (push_op),
      .full_o  (full),
      .pop_i   (pop),
      .data_o  (pop_op),
      .empty_o (empty)
   );

   bfpd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .op_i    (pop_op),
      .empty_i (empty),
      .pop_o   (pop),
      .rsp     (rsp_bus)
   );
endmodule
`default_nettype wire
